>>> rtl/rar_pkg.sv
package rar_pkg;

  localparam int VALUE_BITS = 16;
  localparam int OUT_BITS   = 2 * VALUE_BITS + 1;
  localparam int PROD_BITS  = 2 * VALUE_BITS;
  localparam int CNT_BITS   = $clog2(OUT_BITS);

  typedef struct packed {
    logic [VALUE_BITS-1:0] first_num;
    logic [VALUE_BITS-1:0] first_den;
    logic [VALUE_BITS-1:0] second_num;
    logic [VALUE_BITS-1:0] second_den;
  } in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] mid_num;
    logic [OUT_BITS-1:0] mid_den;
  } out_t;

  typedef struct packed {
    logic                start;
    logic [OUT_BITS-1:0] dividend;
    logic [OUT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [OUT_BITS-1:0] quotient;
    logic [OUT_BITS-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AD,
    ST_MUL_CB,
    ST_MUL_BD,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_QNUM_START,
    ST_QNUM_WAIT,
    ST_QDEN_START,
    ST_QDEN_WAIT,
    ST_FIN
  } state_t;

endpackage

>>> rtl/rar_div.sv
module rar_div import rar_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // restoring divider, one quotient bit per cycle
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [OUT_BITS-1:0] rem_r, rem_nxt;
  logic [OUT_BITS-1:0] quo_r, quo_nxt;
  logic [OUT_BITS-1:0] dsr_r, dsr_nxt;
  logic [OUT_BITS:0]   shifted;
  logic [OUT_BITS:0]   diff;

  assign shifted = {rem_r, quo_r[OUT_BITS-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (diff[OUT_BITS]) begin
        rem_nxt = shifted[OUT_BITS-1:0];
      end else begin
        rem_nxt = diff[OUT_BITS-1:0];
      end
      quo_nxt = {quo_r[OUT_BITS-2:0], ~diff[OUT_BITS]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_BITS'(OUT_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> rtl/rational_average_reduce.sv
// channel | ports                          | beat carries
// --------+--------------------------------+-------------------------------------
// in      | in_valid, in_ready, in_data    | two rationals a/b and c/d, 16b each
// out     | out_valid, out_ready, out_data | reduced midpoint, 33b num and den
//
// steps: 3 multiply steps, then (E + 2) divisions on the shared bit-serial divider
//   (E = euclid remainder steps), then the handover in ST_FIN
// a zero denominator skips the divider and returns 0/0
// reset: rst_n low at a clock edge empties the block and drops out_valid
// stalls: a finished result sits in the output register; the next beat is
//   taken meanwhile and only waits at its end while the register is full
module rational_average_reduce import rar_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t              state_r, state_nxt;
  in_t                 op_r, op_nxt;
  // midpoint before reduction
  logic [OUT_BITS-1:0] num_r, num_nxt;
  logic [OUT_BITS-1:0] den_r, den_nxt;
  // euclid pair, q_r ends up holding the gcd
  logic [OUT_BITS-1:0] p_r, p_nxt;
  logic [OUT_BITS-1:0] q_r, q_nxt;
  logic [OUT_BITS-1:0] rnum_r, rnum_nxt;
  logic [OUT_BITS-1:0] rden_r, rden_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  // one shared 16x16 multiplier
  logic [VALUE_BITS-1:0] mul_a, mul_b;
  logic [PROD_BITS-1:0]  mul_out;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rar_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign mul_out = mul_a * mul_b;

  always_comb begin
    case (state_r)
      ST_MUL_CB: begin
        mul_a = op_r.second_num;
        mul_b = op_r.first_den;
      end
      ST_MUL_BD: begin
        mul_a = op_r.first_den;
        mul_b = op_r.second_den;
      end
      default: begin
        mul_a = op_r.first_num;
        mul_b = op_r.second_den;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    rnum_nxt      = rnum_r;
    rden_nxt      = rden_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req       = '0;
    in_ready      = (state_r == ST_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data;
          state_nxt = ST_MUL_AD;
        end
      end
      ST_MUL_AD: begin
        num_nxt   = OUT_BITS'(mul_out);
        state_nxt = ST_MUL_CB;
      end
      ST_MUL_CB: begin
        num_nxt   = num_r + OUT_BITS'(mul_out);
        state_nxt = ST_MUL_BD;
      end
      ST_MUL_BD: begin
        den_nxt = {mul_out, 1'b0};
        p_nxt   = num_r;
        q_nxt   = {mul_out, 1'b0};
        if (mul_out == '0) begin
          // undefined midpoint, flagged as 0/0
          rnum_nxt  = '0;
          rden_nxt  = '0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_GCD_START;
        end
      end
      ST_GCD_START: begin
        if (p_r == '0) begin
          state_nxt = ST_QNUM_START;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = q_r;
          div_req.divisor  = p_r;
          state_nxt        = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          q_nxt     = p_r;
          p_nxt     = div_rsp.remainder;
          state_nxt = ST_GCD_START;
        end
      end
      ST_QNUM_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_r;
        div_req.divisor  = q_r;
        state_nxt        = ST_QNUM_WAIT;
      end
      ST_QNUM_WAIT: begin
        if (div_rsp.done) begin
          rnum_nxt  = div_rsp.quotient;
          state_nxt = ST_QDEN_START;
        end
      end
      ST_QDEN_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = den_r;
        div_req.divisor  = q_r;
        state_nxt        = ST_QDEN_WAIT;
      end
      ST_QDEN_WAIT: begin
        if (div_rsp.done) begin
          rden_nxt  = div_rsp.quotient;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.mid_num = rnum_r;
          out_data_nxt.mid_den = rden_r;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    rnum_r     <= rnum_nxt;
    rden_r     <= rden_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider is never started with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with zero divisor");

  // divider only reports back while the sequencer is waiting on it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_GCD_WAIT || state_r == ST_QNUM_WAIT ||
                      state_r == ST_QDEN_WAIT))
    else $error("divider done outside a wait state");

  // the gcd divides the numerator exactly
  a_gcd_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (div_rsp.done && state_r == ST_QNUM_WAIT) |-> (div_rsp.remainder == '0))
    else $error("gcd does not divide numerator");

  // a zero denominator only ever comes with a zero numerator
  a_err_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.mid_den == '0) |-> (out_data.mid_num == '0))
    else $error("zero denominator with nonzero numerator");

endmodule
